/* rtl/core/cdq_pkg.sv */
// Shared types, constants and helper functions for the credit-gated priority deque.
`default_nettype none
package cdq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int NUM_ZONES   = 4;
  localparam int CREDIT_W    = 16;
  localparam int ENTRY_W     = 51;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_GRANT = 2'd1,
    OP_POP   = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NO_CREDIT = 3'd3,
    ST_STOPPED   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    TK_RIGHT    = 2'd0,
    TK_STRAIGHT = 2'd1,
    TK_LEFT     = 2'd2,
    TK_OTHER    = 2'd3
  } turn_t;

  // One stored word: vehicle id, urgent flag, turn and arrival time.
  typedef struct packed {
    logic [15:0] vid;
    logic        urg;
    logic [1:0]  turn;
    logic [31:0] arrival;
  } entry_t;

  // A right turn needs the approach's own zone, straight two zones, a left three.
  function automatic logic [NUM_ZONES-1:0] zones_for(input logic [1:0] approach,
                                                     input logic [1:0] turn);
    logic [NUM_ZONES-1:0] mask;
    logic [1:0]           n;
    logic [1:0]           z;
    mask = '0;
    unique case (turn_t'(turn))
      TK_RIGHT:    n = 2'd1;
      TK_STRAIGHT: n = 2'd2;
      TK_LEFT:     n = 2'd3;
      TK_OTHER:    n = 2'd3;
      default:     n = 2'd3;
    endcase
    for (int i = 0; i < 3; i++) begin
      z = approach + 2'(i);
      if (2'(i) < n) begin
        mask[z] = 1'b1;
      end
    end
    return mask;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/cdq_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module cdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/credit_gated_priority_deque_core.sv */
// Top level of the credit-gated priority deque: control, pointers, credits and result register.
`default_nettype none
// One approach road's vehicle queue. Pushes put normal entries at the tail and
// urgent ones in front of the head; a pop needs both an entry and a credit and
// returns the head entry with its wait and conflict-zone mask. The block works
// on one word at a time: push, grant, shut-down and failed pops place their
// result in the output register on acceptance; a successful pop goes through
// the read state first, as the entry comes from a RAM with a registered read.
// in_ready is high only while no word is in flight, so a new word waits until
// the previous result has been taken at the output.
// Entries are stored only in the RAM; no clearing pass runs after reset.
module credit_gated_priority_deque_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [1:0]                  cfg_wr_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_opcode,
  input  wire logic [15:0]                 in_vehicle_id,
  input  wire logic                        in_urgent_flag,
  input  wire logic [1:0]                  in_turn_kind,
  input  wire logic [31:0]                 in_arrival_time,
  input  wire logic [7:0]                  in_grant_amount,
  input  wire logic [31:0]                 in_current_time,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [2:0]                       out_status,
  output logic [15:0]                      out_vehicle_id,
  output logic                             out_urgent,
  output logic [1:0]                       out_turn,
  output logic [31:0]                      out_wait_time,
  output logic [cdq_pkg::NUM_ZONES-1:0]    out_zone_mask,
  output logic [cdq_pkg::CNT_W-1:0]        out_occupancy,
  output logic [cdq_pkg::CREDIT_W-1:0]     out_credits_left
);
  import cdq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [1:0]            approach_r;
  logic [PTR_W-1:0]      head_r, head_nxt;
  logic [PTR_W-1:0]      tail_r, tail_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CREDIT_W-1:0]   credit_r, credit_nxt;
  logic                  stopped_r, stopped_nxt;

  status_t               status_r, status_nxt;
  logic [15:0]           vid_r, vid_nxt;
  logic                  urg_r, urg_nxt;
  logic [1:0]            turn_r, turn_nxt;
  logic [31:0]           wait_r, wait_nxt;
  logic [NUM_ZONES-1:0]  zone_r, zone_nxt;
  logic [31:0]           now_r, now_nxt;

  logic                  ram_we;
  logic [PTR_W-1:0]      ram_waddr;
  entry_t                ram_wdata;
  logic                  ram_re;
  entry_t                ram_rdata;

  logic                  accept;
  logic                  pop_ok;
  logic [CREDIT_W:0]     credit_sum;
  logic [PTR_W-1:0]      head_dec;
  logic [PTR_W-1:0]      tail_inc;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign credit_sum = {1'b0, credit_r} + (CREDIT_W + 1)'(in_grant_amount);
  assign head_dec   = (head_r == '0) ? PTR_W'(QUEUE_DEPTH - 1) : head_r - 1'b1;
  assign tail_inc   = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;

  assign pop_ok = accept && !stopped_r && (op_t'(in_opcode) == OP_POP)
                  && (count_r != '0) && (credit_r != '0);

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    credit_nxt  = credit_r;
    stopped_nxt = stopped_r;
    status_nxt  = status_r;
    vid_nxt     = vid_r;
    urg_nxt     = urg_r;
    turn_nxt    = turn_r;
    wait_nxt    = wait_r;
    zone_nxt    = zone_r;
    now_nxt     = now_r;
    ram_we      = 1'b0;
    ram_waddr   = tail_r;
    ram_wdata   = '{vid: in_vehicle_id, urg: in_urgent_flag, turn: in_turn_kind,
                    arrival: in_arrival_time};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt = ST_DONE;
          vid_nxt    = '0;
          urg_nxt    = 1'b0;
          turn_nxt   = '0;
          wait_nxt   = '0;
          zone_nxt   = '0;
          now_nxt    = in_current_time;
          state_nxt  = S_OUT;
          priority if (op_t'(in_opcode) == OP_STOP) begin
            status_nxt  = stopped_r ? ST_STOPPED : ST_DONE;
            stopped_nxt = 1'b1;
          end else if (stopped_r) begin
            status_nxt = ST_STOPPED;
          end else begin
            unique case (op_t'(in_opcode))
              OP_PUSH: begin
                if (count_r == CNT_W'(QUEUE_DEPTH)) begin
                  status_nxt = ST_FULL;
                end else begin
                  ram_we    = 1'b1;
                  count_nxt = count_r + 1'b1;
                  if (in_urgent_flag) begin
                    ram_waddr = head_dec;
                    head_nxt  = head_dec;
                  end else begin
                    ram_waddr = tail_r;
                    tail_nxt  = tail_inc;
                  end
                end
              end
              OP_GRANT: begin
                credit_nxt = credit_sum[CREDIT_W] ? '1 : credit_sum[CREDIT_W-1:0];
              end
              OP_POP: begin
                priority if (count_r == '0) begin
                  status_nxt = ST_EMPTY;
                end else if (credit_r == '0) begin
                  status_nxt = ST_NO_CREDIT;
                end else begin
                  // The head entry arrives from the RAM in the next cycle.
                  head_nxt   = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
                  count_nxt  = count_r - 1'b1;
                  credit_nxt = credit_r - 1'b1;
                  state_nxt  = S_READ;
                end
              end
              OP_STOP: begin
                stopped_nxt = 1'b1;
              end
              default: begin
                state_nxt = S_OUT;
              end
            endcase
          end
        end
      end
      S_READ: begin
        vid_nxt   = ram_rdata.vid;
        urg_nxt   = ram_rdata.urg;
        turn_nxt  = ram_rdata.turn;
        wait_nxt  = now_r - ram_rdata.arrival;
        zone_nxt  = zones_for(approach_r, ram_rdata.turn);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign ram_re = pop_ok;

  cdq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      approach_r <= '0;
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
      credit_r   <= '0;
      stopped_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      credit_r  <= credit_nxt;
      stopped_r <= stopped_nxt;
      if (cfg_wr_en) begin
        approach_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    vid_r    <= vid_nxt;
    urg_r    <= urg_nxt;
    turn_r   <= turn_nxt;
    wait_r   <= wait_nxt;
    zone_r   <= zone_nxt;
    now_r    <= now_nxt;
  end

  assign out_valid        = (state_r == S_OUT);
  assign out_status       = status_r;
  assign out_vehicle_id   = vid_r;
  assign out_urgent       = urg_r;
  assign out_turn         = turn_r;
  assign out_wait_time    = wait_r;
  assign out_zone_mask    = zone_r;
  assign out_occupancy    = count_r;
  assign out_credits_left = credit_r;

  // The entry count never passes the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  // The RAM read stage is entered only right after a pop was accepted.
  a_read_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> $past(pop_ok))
    else $error("read stage without an accepted pop");

  // A successful pop takes one entry and one credit.
  a_pop_counts: assert property (@(posedge clk) disable iff (!rst_n)
    pop_ok |=> (count_r == $past(count_r) - 1'b1) && (credit_r == $past(credit_r) - 1'b1))
    else $error("pop did not consume an entry and a credit");

  // Once stopped, the block stays stopped until reset.
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |=> stopped_r)
    else $error("stopped flag cleared without reset");

  // A waiting word blocks new input.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input accepted while a word waits at the output");

endmodule
`default_nettype wire

/* bench/tb.sv */
// Self-checking testbench for the credit-gated priority deque core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cdq_pkg::*;

  localparam int LONG_HOLD  = 300;
  localparam int CREDIT_CAP = (1 << CREDIT_W) - 1;

  typedef struct packed {
    logic [15:0] vid;
    logic        urg;
    logic [1:0]  turn;
    logic [31:0] arrival;
  } vehicle_t;

  typedef struct {
    status_t             st;
    logic [15:0]         vid;
    logic                urg;
    logic [1:0]          turn;
    logic [31:0]         wait_us;
    logic [3:0]          zones;
    logic [CNT_W-1:0]    occ;
    logic [CREDIT_W-1:0] credits;
  } deque_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode = '0;
  logic [15:0] in_vehicle_id = '0;
  logic        in_urgent_flag = 1'b0;
  logic [1:0]  in_turn_kind = '0;
  logic [31:0] in_arrival_time = '0;
  logic [7:0]  in_grant_amount = '0;
  logic [31:0] in_current_time = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [15:0] out_vehicle_id;
  logic        out_urgent;
  logic [1:0]  out_turn;
  logic [31:0] out_wait_time;
  logic [NUM_ZONES-1:0]  out_zone_mask;
  logic [CNT_W-1:0]      out_occupancy;
  logic [CREDIT_W-1:0]   out_credits_left;

  // Shadow copy of the queue, its pointers, credits and the approach register.
  vehicle_t             lane [QUEUE_DEPTH];
  logic [PTR_W-1:0]     front_ptr = '0;
  logic [PTR_W-1:0]     back_ptr = '0;
  int unsigned          held = 0;
  int unsigned          credits = 0;
  bit                   halted = 1'b0;
  logic [1:0]           approach = '0;

  deque_result_t awaited_results[$];
  int            mismatches = 0;
  bit            gaps_on = 1'b1;
  bit            hold_request = 1'b0;

  credit_gated_priority_deque_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_vehicle_id    (in_vehicle_id),
    .in_urgent_flag   (in_urgent_flag),
    .in_turn_kind     (in_turn_kind),
    .in_arrival_time  (in_arrival_time),
    .in_grant_amount  (in_grant_amount),
    .in_current_time  (in_current_time),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_vehicle_id   (out_vehicle_id),
    .out_urgent       (out_urgent),
    .out_turn         (out_turn),
    .out_wait_time    (out_wait_time),
    .out_zone_mask    (out_zone_mask),
    .out_occupancy    (out_occupancy),
    .out_credits_left (out_credits_left)
  );

  always #5 clk = ~clk;

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int idle_len();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic vehicle_t random_vehicle();
    vehicle_t v;
    v.vid     = 16'($urandom);
    v.urg     = 1'($urandom);
    v.turn    = 2'($urandom);
    v.arrival = $urandom;
    return v;
  endfunction

  // Applies one accepted word to the shadow state and returns what the block must answer.
  function automatic deque_result_t predict_deque(op_t op, vehicle_t v, logic [7:0] grant,
                                                  logic [31:0] now_us);
    deque_result_t r;
    vehicle_t      head_v;
    int            n;
    r.st = ST_DONE;
    r.vid = '0;
    r.urg = 1'b0;
    r.turn = '0;
    r.wait_us = '0;
    r.zones = '0;
    if (op == OP_STOP) begin
      r.st = halted ? ST_STOPPED : ST_DONE;
      halted = 1'b1;
    end else if (halted) begin
      r.st = ST_STOPPED;
    end else begin
      case (op)
        OP_PUSH: begin
          if (held >= QUEUE_DEPTH) begin
            r.st = ST_FULL;
          end else begin
            // Urgent entries go in front of the head, normal ones behind the tail.
            if (v.urg) begin
              front_ptr = front_ptr - 1'b1;
              lane[front_ptr] = v;
            end else begin
              lane[back_ptr] = v;
              back_ptr = back_ptr + 1'b1;
            end
            held++;
          end
        end
        OP_GRANT: begin
          credits = (credits + grant > CREDIT_CAP) ? CREDIT_CAP : credits + grant;
        end
        default: begin
          if (held == 0) begin
            r.st = ST_EMPTY;
          end else if (credits == 0) begin
            r.st = ST_NO_CREDIT;
          end else begin
            head_v = lane[front_ptr];
            r.vid = head_v.vid;
            r.urg = head_v.urg;
            r.turn = head_v.turn;
            r.wait_us = now_us - head_v.arrival;
            n = (head_v.turn == TK_RIGHT) ? 1 : (head_v.turn == TK_STRAIGHT) ? 2 : 3;
            for (int i = 0; i < n; i++) begin
              r.zones[(approach + i) % NUM_ZONES] = 1'b1;
            end
            front_ptr = front_ptr + 1'b1;
            held--;
            credits--;
          end
        end
      endcase
    end
    r.occ = CNT_W'(held);
    r.credits = CREDIT_W'(credits);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("tb: mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    end
  endtask

  task automatic send_word(op_t op, vehicle_t v, logic [7:0] grant, logic [31:0] now_us);
    int gap;
    gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_vehicle_id   <= v.vid;
    in_urgent_flag  <= v.urg;
    in_turn_kind    <= v.turn;
    in_arrival_time <= v.arrival;
    in_grant_amount <= grant;
    in_current_time <= now_us;
    do @(posedge clk); while (!in_ready);
    awaited_results.push_back(predict_deque(op, v, grant, now_us));
  endtask

  task automatic push_vehicle(logic [15:0] vid, logic urg, logic [1:0] turn, logic [31:0] arr);
    send_word(OP_PUSH, vehicle_t'{vid, urg, turn, arr}, 8'($urandom), $urandom);
  endtask

  task automatic grant_credits(logic [7:0] amount);
    send_word(OP_GRANT, random_vehicle(), amount, $urandom);
  endtask

  task automatic pop_vehicle(logic [31:0] now_us);
    send_word(OP_POP, random_vehicle(), 8'($urandom), now_us);
  endtask

  task automatic shut_down();
    send_word(OP_STOP, random_vehicle(), 8'($urandom), $urandom);
  endtask

  // Drops valid and waits until every awaited word has come back.
  task automatic await_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_approach(logic [1:0] road);
    await_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= road;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    approach = road;
  endtask

  // Empty pops, missing credit, wrapped waits, urgent push at pointer zero and all four turns.
  task automatic test_directed_basics();
    gaps_on = 1'b1;
    set_approach(2'd0);
    pop_vehicle(32'd5);
    grant_credits(8'd0);
    pop_vehicle(32'd5);
    push_vehicle(16'hFFFF, 1'b0, TK_OTHER, 32'hFFFF_FFFF);
    pop_vehicle(32'd100);
    grant_credits(8'd1);
    pop_vehicle(32'd0);
    push_vehicle(16'h0000, 1'b1, TK_RIGHT, 32'd0);
    push_vehicle(16'h1234, 1'b0, TK_STRAIGHT, 32'h8000_0000);
    push_vehicle(16'hA5A5, 1'b1, TK_LEFT, 32'h0000_0001);
    grant_credits(8'd255);
    pop_vehicle(32'hFFFF_FFFF);
    pop_vehicle(32'hFFFF_FFFF);
    pop_vehicle(32'h0000_0000);
    pop_vehicle(32'h7FFF_FFFF);
  endtask

  // Pushes past the queue depth behind a long hold at the result side, then drains it.
  task automatic test_full_queue_backpressure();
    set_approach(2'd3);
    grant_credits(8'd255);
    gaps_on = 1'b0;
    hold_request = 1'b1;
    repeat (QUEUE_DEPTH + 2) begin
      push_vehicle(16'($urandom), 1'($urandom), 2'($urandom), $urandom);
    end
    gaps_on = 1'b1;
    repeat (QUEUE_DEPTH + 2) pop_vehicle($urandom);
  endtask

  task automatic run_traffic(int items, int push_pct, int pop_pct, int max_grant);
    int pick;
    repeat (items) begin
      pick = $urandom_range(0, 99);
      if (pick < push_pct) begin
        push_vehicle(16'($urandom), 1'($urandom), 2'($urandom), $urandom);
      end else if (pick < push_pct + pop_pct) begin
        pop_vehicle($urandom);
      end else begin
        grant_credits(8'($urandom_range(0, max_grant)));
      end
    end
  endtask

  // Mixed traffic on every approach road, with and without idle cycles.
  task automatic test_random_traffic();
    set_approach(2'd0);
    gaps_on = 1'b1;
    run_traffic(250, 45, 45, 3);
    set_approach(2'd3);
    gaps_on = 1'b0;
    run_traffic(250, 60, 30, 2);
    set_approach(2'd1);
    gaps_on = 1'b1;
    run_traffic(250, 30, 55, 8);
    set_approach(2'd2);
    run_traffic(300, 45, 40, 255);
  endtask

  // Large grants until the credit counter sticks at its maximum, then a push, a pop and small grants.
  task automatic test_credit_saturation();
    while (credits != CREDIT_CAP) grant_credits(8'($urandom_range(128, 255)));
    grant_credits(8'd255);
    grant_credits(8'd255);
    push_vehicle(16'($urandom), 1'b0, TK_LEFT, $urandom);
    pop_vehicle($urandom);
    grant_credits(8'd1);
    grant_credits(8'd0);
  endtask

  // After a shut-down every word answers stopped, a second shut-down included.
  task automatic test_shutdown();
    push_vehicle(16'($urandom), 1'b0, TK_RIGHT, $urandom);
    shut_down();
    push_vehicle(16'($urandom), 1'b1, TK_STRAIGHT, $urandom);
    grant_credits(8'd10);
    pop_vehicle($urandom);
    shut_down();
  endtask

  initial begin : result_sink
    int stall_left;
    int g;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        g = idle_len();
        if (g > 0) begin
          out_ready <= 1'b0;
          stall_left = g - 1;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    deque_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result word arrived with none awaited");
      end else begin
        want = awaited_results.pop_front();
        check_field("status", 32'(out_status), 32'(want.st));
        check_field("vehicle_id", 32'(out_vehicle_id), 32'(want.vid));
        check_field("urgent", 32'(out_urgent), 32'(want.urg));
        check_field("turn", 32'(out_turn), 32'(want.turn));
        check_field("wait_time", out_wait_time, want.wait_us);
        check_field("zone_mask", 32'(out_zone_mask), 32'(want.zones));
        check_field("occupancy", 32'(out_occupancy), 32'(want.occ));
        check_field("credits_left", 32'(out_credits_left), 32'(want.credits));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_basics();
    test_full_queue_backpressure();
    test_random_traffic();
    test_credit_saturation();
    test_shutdown();
    await_idle();
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

/* credit_gated_priority_deque_core.f */
rtl/core/cdq_pkg.sv
rtl/core/cdq_ram.sv
rtl/core/credit_gated_priority_deque_core.sv
bench/tb.sv
